// ===== sv/eatrm_pkg.sv =====
// Package for the Euler angle to rotation matrix pipeline.
// Holds the CORDIC arctangent table and fixed scale constants; no dependencies.
`timescale 1ns / 1ps
package eatrm_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] DEG_TO_PHASE = 32'd1527099483;
  localparam logic [31:0] RAD_TO_PHASE = 32'd1367130551;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef logic signed [33:0] q30_t;

  function automatic logic [31:0] atan_phase(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Q1.30 product rounded to nearest, ties toward plus infinity.
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

endpackage

// ===== sv/euler_angles_to_rotation_matrix.sv =====
// Top level: Z-Y-X Tait-Bryan angles to 3x3 rotation matrix, fully pipelined.
// Depends on eatrm_pkg for the CORDIC table and the rounding multiply.
`timescale 1ns / 1ps
// Stages: 2 phase, 30 CORDIC, 1 fold, 2 products, 1 sum, 1 output rounding;
// the rounding stage is the output register.
// Throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being taken, so a stall freezes every stage.
// Reset (synchronous, rst_n low) clears all valid bits and sets
// cfg_angle_in_degrees to 1 (degrees). Payload registers are not reset.
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_angle_in_degrees,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_yaw_angle,
  input  logic signed [31:0]            in_pitch_angle,
  input  logic signed [31:0]            in_roll_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_FRAC_BITS+1:0] out_m00,
  output logic signed [OUT_FRAC_BITS+1:0] out_m01,
  output logic signed [OUT_FRAC_BITS+1:0] out_m02,
  output logic signed [OUT_FRAC_BITS+1:0] out_m10,
  output logic signed [OUT_FRAC_BITS+1:0] out_m11,
  output logic signed [OUT_FRAC_BITS+1:0] out_m12,
  output logic signed [OUT_FRAC_BITS+1:0] out_m20,
  output logic signed [OUT_FRAC_BITS+1:0] out_m21,
  output logic signed [OUT_FRAC_BITS+1:0] out_m22
);
  import eatrm_pkg::*;

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int NS = CORDIC_STEPS;
  // Pipeline stages: 0..1 phase, 2..NS+1 CORDIC, then fold, p1, p2, sum, out.
  localparam int NV = NS + 7;

  logic deg_r;
  logic adv;
  logic [NV-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b1;
    end else if (cfg_we) begin
      deg_r <= cfg_angle_in_degrees;
    end
  end

  // The pipe moves as a whole whenever the output slot can take a result.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NV-2:0], in_valid};
    end
  end

  // Phase stage 1: 32x31 multiply by the turn scale.
  logic signed [63:0] prod_r [3];
  // Phase stage 2: round, fold into quadrant, seed CORDIC.
  logic signed [33:0] x_r [3][NS+1];
  logic signed [33:0] y_r [3][NS+1];
  logic signed [32:0] z_r [3][NS+1];
  logic [1:0]         q_r [3][NS+1];
  logic signed [31:0] ang [3];
  assign ang[0] = in_yaw_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_roll_angle;

  q30_t s_r [3];
  q30_t c_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic signed [63:0] rnd;
    logic [31:0] phase, rr;
    logic [1:0] q;
    always_comb begin
      if (deg_r) begin
        rnd = (prod_r[a] + (64'sd1 <<< (ANGLE_FRAC_BITS + 6))) >>> (ANGLE_FRAC_BITS + 7);
      end else begin
        rnd = (prod_r[a] + (64'sd1 <<< ANGLE_FRAC_BITS)) >>> (ANGLE_FRAC_BITS + 1);
      end
      phase = rnd[31:0];
      q = 2'(({2'b00, phase} + 34'h020000000) >> 30);
      rr = phase - {q, 30'd0};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[a] <= ang[a] * $signed({1'b0, deg_r ? DEG_TO_PHASE : RAD_TO_PHASE});
        x_r[a][0] <= CORDIC_GAIN_INV;
        y_r[a][0] <= '0;
        z_r[a][0] <= {rr[31], rr};
        q_r[a][0] <= q;
      end
    end
    for (genvar i = 0; i < NS; i++) begin : g_it
      logic signed [33:0] xs, ys;
      logic signed [32:0] at;
      assign xs = x_r[a][i] >>> i;
      assign ys = y_r[a][i] >>> i;
      assign at = {1'b0, atan_phase(5'(i))};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!z_r[a][i][32]) begin
            x_r[a][i+1] <= x_r[a][i] - ys;
            y_r[a][i+1] <= y_r[a][i] + xs;
            z_r[a][i+1] <= z_r[a][i] - at;
          end else begin
            x_r[a][i+1] <= x_r[a][i] + ys;
            y_r[a][i+1] <= y_r[a][i] - xs;
            z_r[a][i+1] <= z_r[a][i] + at;
          end
          q_r[a][i+1] <= q_r[a][i];
        end
      end
    end
    // Clamp and quadrant fold.
    q30_t c, s;
    assign c = (x_r[a][NS] > ONE_Q30) ? ONE_Q30 :
               (x_r[a][NS] < -ONE_Q30) ? -ONE_Q30 : x_r[a][NS];
    assign s = (y_r[a][NS] > ONE_Q30) ? ONE_Q30 :
               (y_r[a][NS] < -ONE_Q30) ? -ONE_Q30 : y_r[a][NS];
    always_ff @(posedge clk) begin
      if (adv) begin
        case (q_r[a][NS])
          2'd0: begin c_r[a] <= c;  s_r[a] <= s;  end
          2'd1: begin c_r[a] <= -s; s_r[a] <= c;  end
          2'd2: begin c_r[a] <= -c; s_r[a] <= -s; end
          default: begin c_r[a] <= s; s_r[a] <= -c; end
        endcase
      end
    end
  end

  // Product stage 1: two-factor products and carried factors.
  q30_t casb_r, sasb_r, cacb_r, sacb_r, sacg_r, sasg_r, cacg_r, casg_r;
  q30_t cbsg_r, cbcg_r, nsb_r, sg1_r, cg1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      casb_r <= mul_q30(c_r[0], s_r[1]);
      sasb_r <= mul_q30(s_r[0], s_r[1]);
      cacb_r <= mul_q30(c_r[0], c_r[1]);
      sacb_r <= mul_q30(s_r[0], c_r[1]);
      sacg_r <= mul_q30(s_r[0], c_r[2]);
      sasg_r <= mul_q30(s_r[0], s_r[2]);
      cacg_r <= mul_q30(c_r[0], c_r[2]);
      casg_r <= mul_q30(c_r[0], s_r[2]);
      cbsg_r <= mul_q30(c_r[1], s_r[2]);
      cbcg_r <= mul_q30(c_r[1], c_r[2]);
      nsb_r  <= -s_r[1];
      sg1_r  <= s_r[2];
      cg1_r  <= c_r[2];
    end
  end

  // Product stage 2: three-factor products, with the two-factor terms carried along.
  q30_t t01_r, t02_r, t11_r, t12_r;
  q30_t d00_r, d10_r, d20_r, d21_r, d22_r, e01_r, e02_r, e11_r, e12_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      t01_r <= mul_q30(casb_r, sg1_r);
      t02_r <= mul_q30(casb_r, cg1_r);
      t11_r <= mul_q30(sasb_r, sg1_r);
      t12_r <= mul_q30(sasb_r, cg1_r);
      e01_r <= sacg_r; e02_r <= sasg_r; e11_r <= cacg_r; e12_r <= casg_r;
      d00_r <= cacb_r; d10_r <= sacb_r; d20_r <= nsb_r;
      d21_r <= cbsg_r; d22_r <= cbcg_r;
    end
  end

  // Sum stage.
  q30_t r_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      r_r[0] <= d00_r;
      r_r[1] <= t01_r - e01_r;
      r_r[2] <= t02_r + e02_r;
      r_r[3] <= d10_r;
      r_r[4] <= t11_r + e11_r;
      r_r[5] <= t12_r - e12_r;
      r_r[6] <= d20_r;
      r_r[7] <= d21_r;
      r_r[8] <= d22_r;
    end
  end

  // Output stage: round to the output format and clamp to plus or minus one.
  localparam int SH = 30 - OUT_FRAC_BITS;
  logic signed [OW-1:0] o_r [9];
  for (genvar k = 0; k < 9; k++) begin : g_out
    logic signed [34:0] rs;
    logic signed [34:0] one;
    logic signed [34:0] mone;
    assign one = 35'sd1 <<< OUT_FRAC_BITS;
    assign mone = -one;
    always_comb begin
      if (SH == 0) begin
        rs = 35'(r_r[k]);
      end else begin
        rs = (35'(r_r[k]) + (35'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rs > one) begin
          o_r[k] <= one[OW-1:0];
        end else if (rs < mone) begin
          o_r[k] <= mone[OW-1:0];
        end else begin
          o_r[k] <= rs[OW-1:0];
        end
      end
    end
  end

  assign out_valid = v_r[NV-1];
  assign out_m00 = o_r[0];
  assign out_m01 = o_r[1];
  assign out_m02 = o_r[2];
  assign out_m10 = o_r[3];
  assign out_m11 = o_r[4];
  assign out_m12 = o_r[5];
  assign out_m20 = o_r[6];
  assign out_m21 = o_r[7];
  assign out_m22 = o_r[8];

  // A stalled result must hold until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_m00) && $stable(out_m22))
    else $error("result changed while stalled");
  // Whenever the output waits, no new transaction enters.
  a_nostall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during stall");
  // Entry m20 stays inside plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m20 <= (OW'(1) <<< OUT_FRAC_BITS)) &&
                  (out_m20 >= -(OW'(1) <<< OUT_FRAC_BITS)))
    else $error("entry out of range");

endmodule

// ===== tb/sv/tb_euler_angles_to_rotation_matrix.sv =====
// Self-checking testbench for euler_angles_to_rotation_matrix.
// Depends on eatrm_pkg (scale constants and arctangent table) and the block's RTL.
`timescale 1ns / 1ps
module tb_euler_angles_to_rotation_matrix;
  import eatrm_pkg::*;

  // One rotation matrix as nine signed Q1.16 entries, m00 at index 8 down to m22 at index 0.
  typedef logic signed [8:0][17:0] rot_mat_t;

  // A row of the directed table. When has_exp is set, the typed-in matrix is
  // used as the expectation; otherwise the predictor supplies it.
  typedef struct {
    logic signed [31:0] yaw;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
    bit                 has_exp;
    rot_mat_t           mat;
  } angle_row_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;   // 90 degrees in Q15.16
  localparam logic signed [31:0] DEG45  = 32'sd2949120;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] HALF_PI = 32'sd102944;   // pi/2 radians in Q15.16
  localparam logic signed [31:0] PI_RAD  = 32'sd205887;
  localparam logic signed [31:0] MAX_ANG = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_ANG = 32'sh80000000;
  localparam rot_mat_t IDENTITY = {18'sd65536, 18'sd0, 18'sd0,
                                   18'sd0, 18'sd65536, 18'sd0,
                                   18'sd0, 18'sd0, 18'sd65536};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_angle_in_degrees = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_yaw_angle = '0;
  logic signed [31:0] in_pitch_angle = '0;
  logic signed [31:0] in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [17:0] out_m20, out_m21, out_m22;

  // Mirror of the block's unit setting, updated alongside every register write.
  bit units_deg = 1'b1;
  // When set, both sides run without idle gaps.
  bit burst = 1'b0;
  bit finished = 1'b0;
  rot_mat_t pending_mats[$];
  int mismatches = 0;
  int cycles = 0;
  int out_stall = 0;
  string entry_name[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  euler_angles_to_rotation_matrix uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_angle_in_degrees(cfg_angle_in_degrees),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_yaw_angle(in_yaw_angle),
    .in_pitch_angle(in_pitch_angle),
    .in_roll_angle(in_roll_angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_m00(out_m00),
    .out_m01(out_m01),
    .out_m02(out_m02),
    .out_m10(out_m10),
    .out_m11(out_m11),
    .out_m12(out_m12),
    .out_m20(out_m20),
    .out_m21(out_m21),
    .out_m22(out_m22)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Add half an LSB and floor; >>> on a longint is an arithmetic (floor) shift.
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(input longint v, input longint one);
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shr(a * b, 30);
  endfunction

  // Angle to a 32-bit phase, fold into the quadrant around zero, then rotate
  // a vector of length 1/gain by 30 CORDIC steps. Results are in Q1.30.
  function automatic void angle_sin_cos(input logic signed [31:0] ang, input bit deg,
                                        output longint sn, output longint cs);
    longint prod, ph, x, y, z, nx, c, s;
    logic [31:0] phase, folded;
    logic [1:0] quad;
    prod = longint'(ang) * (deg ? longint'(DEG_TO_PHASE) : longint'(RAD_TO_PHASE));
    ph = round_shr(prod, deg ? 23 : 17);
    phase = ph[31:0];
    quad = 2'((phase + 32'h2000_0000) >> 30);
    folded = phase - {quad, 30'b0};
    z = longint'(signed'(folded));
    x = longint'(CORDIC_GAIN_INV);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(atan_phase(5'(i)));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(atan_phase(5'(i)));
      end
      x = nx;
    end
    c = clamp_unit(x, 64'sd1073741824);
    s = clamp_unit(y, 64'sd1073741824);
    case (quad)
      2'd0: begin cs = c; sn = s; end
      2'd1: begin cs = -s; sn = c; end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  function automatic logic signed [17:0] to_q16(input longint v);
    longint r;
    r = clamp_unit(round_shr(v, 14), 64'sd65536);
    return r[17:0];
  endfunction

  // Z-Y-X rotation matrix, Rz(yaw) * Ry(pitch) * Rx(roll).
  function automatic rot_mat_t zyx_matrix(input logic signed [31:0] yaw,
                                          input logic signed [31:0] pitch,
                                          input logic signed [31:0] roll,
                                          input bit deg);
    longint sa, ca, sb, cb, sg, cg, casb, sasb;
    rot_mat_t m;
    angle_sin_cos(yaw, deg, sa, ca);
    angle_sin_cos(pitch, deg, sb, cb);
    angle_sin_cos(roll, deg, sg, cg);
    casb = qmul(ca, sb);
    sasb = qmul(sa, sb);
    m[8] = to_q16(qmul(ca, cb));
    m[7] = to_q16(qmul(casb, sg) - qmul(sa, cg));
    m[6] = to_q16(qmul(casb, cg) + qmul(sa, sg));
    m[5] = to_q16(qmul(sa, cb));
    m[4] = to_q16(qmul(sasb, sg) + qmul(ca, cg));
    m[3] = to_q16(qmul(sasb, cg) - qmul(ca, sg));
    m[2] = to_q16(-sb);
    m[1] = to_q16(qmul(cb, sg));
    m[0] = to_q16(qmul(cb, cg));
    return m;
  endfunction

  // Packed index 8 holds m00, so entry k of the printed order is index 8-k.
  always @(posedge clk) begin
    rot_mat_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22};
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result transaction", $realtime);
      end else begin
        want = pending_mats.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[8 - k] !== want[8 - k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] %s expected %0d got %0d", $realtime, entry_name[k],
                       $signed(want[8 - k]), $signed(got[8 - k]));
          end
        end
      end
    end
  end

  // The result side: after most taken transactions, hold ready low for a random
  // number of cycles, unless a burst stretch is in progress.
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && !burst && $urandom_range(0, 12) != 0) begin
      out_stall <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !finished) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one transaction after a random gap and wait for it to be taken. Called
  // and returning at a rising edge; valid stays high when the next gap is zero.
  task automatic send_angles(input logic signed [31:0] yaw, input logic signed [31:0] pitch,
                             input logic signed [31:0] roll, input bit has_exp,
                             input rot_mat_t mat);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_yaw_angle <= yaw;
    in_pitch_angle <= pitch;
    in_roll_angle <= roll;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_mats.push_back(has_exp ? mat : zyx_matrix(yaw, pitch, roll, units_deg));
  endtask

  // Unit changes happen only once the pipe has drained; every input yields a
  // result, so an empty queue means the block is idle.
  task automatic set_units(input bit deg);
    in_valid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_angle_in_degrees <= deg;
    @(posedge clk);
    cfg_we <= 1'b0;
    units_deg = deg;
  endtask

  function automatic logic signed [31:0] draw_angle(input bit deg);
    int span;
    span = deg ? (720 << 16) : (13 << 16);
    if ($urandom_range(0, 9) < 6)
      return $urandom;
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0)
        burst = ($urandom_range(0, 3) == 0);
      send_angles(draw_angle(units_deg), draw_angle(units_deg), draw_angle(units_deg),
                  1'b0, IDENTITY);
    end
    burst = 1'b0;
  endtask

  angle_row_t deg_rows[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, IDENTITY},
    '{MAX_ANG, MAX_ANG, MAX_ANG, 1'b0, IDENTITY},
    '{MIN_ANG, MIN_ANG, MIN_ANG, 1'b0, IDENTITY},
    '{MAX_ANG, MIN_ANG, 32'sd0, 1'b0, IDENTITY},
    '{DEG90, 32'sd0, 32'sd0, 1'b0, IDENTITY},
    '{32'sd0, DEG90, 32'sd0, 1'b0, IDENTITY},
    '{32'sd0, 32'sd0, DEG90, 1'b0, IDENTITY},
    '{32'sd0, -DEG90, DEG45, 1'b0, IDENTITY},
    '{DEG180, DEG180, DEG180, 1'b0, IDENTITY},
    '{-DEG180, -DEG45, -DEG90, 1'b0, IDENTITY},
    '{DEG45, DEG45, DEG45, 1'b0, IDENTITY},
    // A whole turn plus 45 degrees must wrap back to 45 degrees.
    '{DEG45 + 4 * DEG90, DEG45, DEG45 - 8 * DEG90, 1'b0, IDENTITY},
    '{32'sd1, -32'sd1, 32'sd65536, 1'b0, IDENTITY}
  };

  angle_row_t rad_rows[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, IDENTITY},
    '{MAX_ANG, MAX_ANG, MAX_ANG, 1'b0, IDENTITY},
    '{MIN_ANG, MIN_ANG, MIN_ANG, 1'b0, IDENTITY},
    '{HALF_PI, HALF_PI, HALF_PI, 1'b0, IDENTITY},
    '{PI_RAD, -HALF_PI, PI_RAD, 1'b0, IDENTITY},
    '{-PI_RAD, 32'sd65536, -32'sd65536, 1'b0, IDENTITY}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Degrees is the reset setting, so the first table runs without a write.
    foreach (deg_rows[i])
      send_angles(deg_rows[i].yaw, deg_rows[i].pitch, deg_rows[i].roll,
                  deg_rows[i].has_exp, deg_rows[i].mat);
    set_units(1'b0);
    foreach (rad_rows[i])
      send_angles(rad_rows[i].yaw, rad_rows[i].pitch, rad_rows[i].roll,
                  rad_rows[i].has_exp, rad_rows[i].mat);
    random_items(340);
    set_units(1'b1);
    random_items(340);
    set_units(1'b0);
    random_items(350);

    in_valid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
    // Let anything stray come out of the 37-stage pipe before judging.
    repeat (60) @(posedge clk);
    finished = 1'b1;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
